>>> hw/rtl/pffha_pkg.sv
package pffha_pkg;

    // shared datapath width: covers 17-bit page candidates and in-page offsets
    localparam int ALU_W = 18;

    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_NEW_PAGE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BAD_ADDR  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD     = 2'd0,
        ALU_ADD_SAT = 2'd1,
        ALU_SUB_SAT = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
        logic [ALU_W-1:0]   c;
        logic [ALU_W-1:0]   x;
        logic [ALU_W-1:0]   y;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0]   res;
        logic               ge;
        logic               eq;
    } alu_rsp_t;

endpackage

>>> hw/rtl/paged_first_fit_heap_allocator.sv
// Channel | Dir | Bits                                   | Meaning
// s_      | in  | tuser[1:0] command; tdata 32           | alloc / free / new page
// m_      | out | tuser[1:0] status; tdata 32            | page, offset, released
// cfg_    | in  | cfg_wdata[15:0]                        | heap_base_page
//
// One word at a time; s_tready is high only while the sequencer is idle.
// new_page: scans the pages in use, one slot compare per cycle, then writes a header.
// alloc: checks slots for free space, walks the headers of a fitting slot, marks the
// block taken and writes any split tail; free: finds the slot, rewrites the header;
// on success both run the coalesce walk. Page, free-count and offset arithmetic
// goes through the single shared ALU, headers through a RAM with one registered read port.
// Reset: synchronous active-low aresetn; no clearing pass, header RAM is
// undefined until written. A finished word waits in the output register while
// m_tready is low; the next command is already accepted meanwhile.
module paged_first_fit_heap_allocator #(
    parameter int PAGE_BYTES   = 256,
    parameter int NUM_PAGES    = 8,
    parameter int HEADER_BYTES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,     // heap_base_page
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // size[7:0], page[23:8], offset[31:24]
    input  logic [1:0]  s_tuser,       // command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // result_page[15:0], block_offset[23:16],
                                       // page_released[24], zero fill
    output logic [1:0]  m_tuser        // status
);
    import pffha_pkg::*;

    localparam int CNT_MAX = 2 * PAGE_BYTES - 1;
    localparam int SW      = $clog2(2 * PAGE_BYTES);          // block size bits
    localparam int PW      = $clog2(PAGE_BYTES);              // in-page index bits
    localparam int OW      = PW + 2;                          // walk offset bits
    localparam int SLW     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW      = $clog2(NUM_PAGES + 1);
    localparam int DEPTH   = NUM_PAGES * PAGE_BYTES;
    localparam int AW      = $clog2(DEPTH);
    localparam int SHW     = $clog2(256 + HEADER_BYTES);
    localparam int FIT_MAX = PAGE_BYTES - HEADER_BYTES;

    typedef enum logic [19:0] {
        S_IDLE     = 20'b00000000000000000001,
        S_NP_SCAN  = 20'b00000000000000000010,
        S_NP_WR    = 20'b00000000000000000100,
        S_AL_SLOT  = 20'b00000000000000001000,
        S_AL_RD    = 20'b00000000000000010000,
        S_AL_CHK   = 20'b00000000000000100000,
        S_AL_W1    = 20'b00000000000001000000,
        S_AL_N     = 20'b00000000000010000000,
        S_AL_W2    = 20'b00000000000100000000,
        S_FR_SCAN  = 20'b00000000001000000000,
        S_FR_RD    = 20'b00000000010000000000,
        S_FR_WR    = 20'b00000000100000000000,
        S_CO_START = 20'b00000001000000000000,
        S_CO_H0    = 20'b00000010000000000000,
        S_CO_RD    = 20'b00000100000000000000,
        S_CO_CHK   = 20'b00001000000000000000,
        S_CO_MRG   = 20'b00010000000000000000,
        S_CO_FB    = 20'b00100000000000000000,
        S_CO_END   = 20'b01000000000000000000,
        S_DONE     = 20'b10000000000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [15:0]      base_reg, base_next;
    logic [CW-1:0]    piu_reg, piu_next;
    logic [CW-1:0]    slot_cnt_reg, slot_cnt_next;
    logic [7:0]       size_reg, size_next;
    logic [SHW-1:0]   size_h_reg, size_h_next;
    logic [15:0]      page_reg, page_next;
    logic [16:0]      cand_reg, cand_next;
    logic [OW-1:0]    off_reg, off_next;
    logic [OW-1:0]    hoff_reg, hoff_next;
    logic [OW-1:0]    prev_off_reg, prev_off_next;
    logic             prev_free_reg, prev_free_next;
    logic [SW-1:0]    prev_size_reg, prev_size_next;
    logic [SW-1:0]    hsize_reg, hsize_next;
    logic [15:0]      slot_page_reg [NUM_PAGES];
    logic [15:0]      slot_page_next [NUM_PAGES];
    logic [SW-1:0]    slot_free_reg [NUM_PAGES];
    logic [SW-1:0]    slot_free_next [NUM_PAGES];
    status_t          res_status_reg, res_status_next;
    logic [15:0]      res_page_reg, res_page_next;
    logic [7:0]       res_off_reg, res_off_next;
    logic             res_rel_reg, res_rel_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [15:0]      m_page_reg, m_page_next;
    logic [7:0]       m_off_reg, m_off_next;
    logic             m_rel_reg, m_rel_next;

    // header RAM: {free, size}
    logic [SW:0]      hdr_mem [DEPTH];
    logic [SW:0]      rd_q;
    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [SW:0]      mem_wd;

    alu_req_t         alu_req;
    alu_rsp_t         alu_rsp;
    logic [SLW-1:0]   slot_idx;
    logic             hdr_free;
    logic [SW-1:0]    hdr_size;

    function automatic logic [AW-1:0] hdr_addr(input logic [SLW-1:0] s,
                                               input logic [OW-1:0]  o);
        return AW'(AW'(s) * AW'(PAGE_BYTES)) + AW'(o[PW-1:0]);
    endfunction

    pffha_alu #(.SAT_MAX(CNT_MAX)) u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign slot_idx = slot_cnt_reg[SLW-1:0];
    assign hdr_free = rd_q[SW];
    assign hdr_size = rd_q[SW-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_rel_reg, m_off_reg, m_page_reg};

    always_comb begin
        state_next     = state_reg;
        base_next      = cfg_we ? cfg_wdata : base_reg;
        piu_next       = piu_reg;
        slot_cnt_next  = slot_cnt_reg;
        size_next      = size_reg;
        size_h_next    = size_h_reg;
        page_next      = page_reg;
        cand_next      = cand_reg;
        off_next       = off_reg;
        hoff_next      = hoff_reg;
        prev_off_next  = prev_off_reg;
        prev_free_next = prev_free_reg;
        prev_size_next = prev_size_reg;
        hsize_next     = hsize_reg;
        slot_page_next = slot_page_reg;
        slot_free_next = slot_free_reg;
        res_status_next = res_status_reg;
        res_page_next  = res_page_reg;
        res_off_next   = res_off_reg;
        res_rel_next   = res_rel_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_status_next  = m_status_reg;
        m_page_next    = m_page_reg;
        m_off_next     = m_off_reg;
        m_rel_next     = m_rel_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = '0;
        alu_req        = '{op: ALU_ADD, a: '0, b: '0, c: '0, x: '0, y: '0};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    size_next     = s_tdata[7:0];
                    size_h_next   = SHW'(s_tdata[7:0]) + SHW'(HEADER_BYTES);
                    page_next     = s_tdata[23:8];
                    hoff_next     = OW'(s_tdata[31:24]);
                    slot_cnt_next = '0;
                    cand_next     = {1'b0, base_reg};
                    res_page_next = '0;
                    res_off_next  = '0;
                    res_rel_next  = 1'b0;
                    case (s_tuser)
                        CMD_NEW_PAGE: begin
                            if (32'(piu_reg) >= 32'(NUM_PAGES)) begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_NP_SCAN;
                            end
                        end
                        CMD_ALLOC: state_next = S_AL_SLOT;
                        CMD_FREE: begin
                            if (32'(s_tdata[31:24]) >= 32'(HEADER_BYTES) &&
                                32'(s_tdata[31:24]) <= 32'(PAGE_BYTES)) begin
                                state_next = S_FR_SCAN;
                            end else begin
                                res_status_next = ST_BAD_ADDR;
                                state_next      = S_DONE;
                            end
                        end
                        default: begin
                            res_status_next = ST_BAD_ADDR;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            // next page number: heap_base_page or past the highest so far, one slot per cycle
            S_NP_SCAN: begin
                if (slot_cnt_reg == piu_reg) begin
                    state_next = S_NP_WR;
                end else begin
                    alu_req.op = ALU_ADD;
                    alu_req.a  = ALU_W'(slot_page_reg[slot_idx]);
                    alu_req.b  = ALU_W'(1);
                    alu_req.x  = ALU_W'(slot_page_reg[slot_idx]);
                    alu_req.y  = ALU_W'(cand_reg);
                    if (alu_rsp.ge) cand_next = alu_rsp.res[16:0];
                    slot_cnt_next = slot_cnt_reg + CW'(1);
                end
            end

            S_NP_WR: begin
                slot_page_next[piu_reg[SLW-1:0]] = cand_reg[15:0];
                slot_free_next[piu_reg[SLW-1:0]] = SW'(FIT_MAX);
                mem_we          = 1'b1;
                mem_wa          = hdr_addr(piu_reg[SLW-1:0], '0);
                mem_wd          = {1'b1, SW'(FIT_MAX)};
                piu_next        = piu_reg + CW'(1);
                res_status_next = ST_OK;
                res_page_next   = cand_reg[15:0];
                state_next      = S_DONE;
            end

            S_AL_SLOT: begin
                if (slot_cnt_reg == piu_reg) begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_DONE;
                end else begin
                    alu_req.x = ALU_W'(slot_free_reg[slot_idx]);
                    alu_req.y = ALU_W'(size_reg);
                    if (alu_rsp.ge) begin
                        off_next   = '0;
                        state_next = S_AL_RD;
                    end else begin
                        slot_cnt_next = slot_cnt_reg + CW'(1);
                    end
                end
            end

            S_AL_RD: begin
                if (off_reg <= OW'(FIT_MAX)) begin
                    mem_ra     = hdr_addr(slot_idx, off_reg);
                    state_next = S_AL_CHK;
                end else begin
                    slot_cnt_next = slot_cnt_reg + CW'(1);
                    state_next    = S_AL_SLOT;
                end
            end

            S_AL_CHK: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(off_reg);
                alu_req.b  = ALU_W'(hdr_size);
                alu_req.c  = ALU_W'(HEADER_BYTES);
                alu_req.x  = ALU_W'(hdr_size);
                alu_req.y  = ALU_W'(size_h_reg);
                if (hdr_free && (alu_rsp.ge || hdr_size == SW'(size_reg))) begin
                    hoff_next  = off_reg;
                    hsize_next = hdr_size;
                    state_next = S_AL_W1;
                end else begin
                    off_next   = alu_rsp.res[OW-1:0];
                    state_next = S_AL_RD;
                end
            end

            S_AL_W1: begin
                mem_we     = 1'b1;
                mem_wa     = hdr_addr(slot_idx, hoff_reg);
                alu_req.op = ALU_SUB_SAT;
                alu_req.a  = ALU_W'(slot_free_reg[slot_idx]);
                if (hsize_reg == SW'(size_reg)) begin
                    mem_wd     = {1'b0, hsize_reg};
                    alu_req.b  = ALU_W'(hsize_reg);
                    state_next = S_CO_START;
                end else begin
                    mem_wd     = {1'b0, SW'(size_reg)};
                    alu_req.b  = ALU_W'(size_h_reg);
                    state_next = S_AL_N;
                end
                slot_free_next[slot_idx] = alu_rsp.res[SW-1:0];
            end

            S_AL_N: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(hoff_reg);
                alu_req.b  = ALU_W'(size_h_reg);
                off_next   = alu_rsp.res[OW-1:0];
                state_next = S_AL_W2;
            end

            // tail of a split block becomes a new free block
            S_AL_W2: begin
                alu_req.op = ALU_SUB_SAT;
                alu_req.a  = ALU_W'(hsize_reg);
                alu_req.b  = ALU_W'(size_h_reg);
                if (off_reg <= OW'(FIT_MAX)) begin
                    mem_we = 1'b1;
                    mem_wa = hdr_addr(slot_idx, off_reg);
                    mem_wd = {1'b1, alu_rsp.res[SW-1:0]};
                end
                state_next = S_CO_START;
            end

            S_FR_SCAN: begin
                if (slot_cnt_reg == piu_reg) begin
                    res_status_next = ST_BAD_ADDR;
                    state_next      = S_DONE;
                end else begin
                    alu_req.op = ALU_SUB_SAT;
                    alu_req.a  = ALU_W'(hoff_reg);
                    alu_req.b  = ALU_W'(HEADER_BYTES);
                    alu_req.x  = ALU_W'(slot_page_reg[slot_idx]);
                    alu_req.y  = ALU_W'(page_reg);
                    if (alu_rsp.eq) begin
                        hoff_next  = alu_rsp.res[OW-1:0];
                        state_next = S_FR_RD;
                    end else begin
                        slot_cnt_next = slot_cnt_reg + CW'(1);
                    end
                end
            end

            S_FR_RD: begin
                mem_ra     = hdr_addr(slot_idx, hoff_reg);
                state_next = S_FR_WR;
            end

            S_FR_WR: begin
                mem_we     = 1'b1;
                mem_wa     = hdr_addr(slot_idx, hoff_reg);
                mem_wd     = {1'b1, hdr_size};
                alu_req.op = ALU_ADD_SAT;
                alu_req.a  = ALU_W'(slot_free_reg[slot_idx]);
                alu_req.b  = ALU_W'(hdr_size);
                slot_free_next[slot_idx] = alu_rsp.res[SW-1:0];
                state_next = S_CO_START;
            end

            // coalesce walk over the page
            S_CO_START: begin
                mem_ra     = hdr_addr(slot_idx, '0);
                state_next = S_CO_H0;
            end

            S_CO_H0: begin
                alu_req.op     = ALU_ADD;
                alu_req.a      = ALU_W'(hdr_size);
                alu_req.b      = ALU_W'(HEADER_BYTES);
                prev_off_next  = '0;
                prev_free_next = hdr_free;
                prev_size_next = hdr_size;
                off_next       = alu_rsp.res[OW-1:0];
                state_next     = S_CO_RD;
            end

            S_CO_RD: begin
                if (off_reg <= OW'(FIT_MAX)) begin
                    mem_ra     = hdr_addr(slot_idx, off_reg);
                    state_next = S_CO_CHK;
                end else begin
                    state_next = S_CO_END;
                end
            end

            S_CO_CHK: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(off_reg);
                alu_req.b  = ALU_W'(HEADER_BYTES);
                alu_req.c  = ALU_W'(hdr_size);
                off_next   = alu_rsp.res[OW-1:0];
                hsize_next = hdr_size;
                if (hdr_free && prev_free_reg) begin
                    state_next = S_CO_MRG;
                end else begin
                    prev_off_next  = off_reg;
                    prev_free_next = hdr_free;
                    prev_size_next = hdr_size;
                    state_next     = S_CO_RD;
                end
            end

            S_CO_MRG: begin
                alu_req.op     = ALU_ADD_SAT;
                alu_req.a      = ALU_W'(prev_size_reg);
                alu_req.b      = ALU_W'(HEADER_BYTES);
                alu_req.c      = ALU_W'(hsize_reg);
                prev_size_next = alu_rsp.res[SW-1:0];
                mem_we         = 1'b1;
                mem_wa         = hdr_addr(slot_idx, prev_off_reg);
                mem_wd         = {1'b1, alu_rsp.res[SW-1:0]};
                state_next     = S_CO_FB;
            end

            S_CO_FB: begin
                alu_req.op = ALU_ADD_SAT;
                alu_req.a  = ALU_W'(slot_free_reg[slot_idx]);
                alu_req.b  = ALU_W'(HEADER_BYTES);
                slot_free_next[slot_idx] = alu_rsp.res[SW-1:0];
                state_next = S_CO_RD;
            end

            S_CO_END: begin
                alu_req.x       = ALU_W'(slot_free_reg[slot_idx]);
                alu_req.y       = ALU_W'(FIT_MAX);
                res_status_next = ST_OK;
                res_page_next   = slot_page_reg[slot_idx];
                res_off_next    = 8'(hoff_reg);
                res_rel_next    = alu_rsp.eq;
                state_next      = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_page_next   = res_page_reg;
                    m_off_next    = res_off_reg;
                    m_rel_next    = res_rel_reg;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            base_reg     <= '0;
            piu_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            piu_reg      <= piu_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_cnt_reg   <= slot_cnt_next;
        size_reg       <= size_next;
        size_h_reg     <= size_h_next;
        page_reg       <= page_next;
        cand_reg       <= cand_next;
        off_reg        <= off_next;
        hoff_reg       <= hoff_next;
        prev_off_reg   <= prev_off_next;
        prev_free_reg  <= prev_free_next;
        prev_size_reg  <= prev_size_next;
        hsize_reg      <= hsize_next;
        slot_page_reg  <= slot_page_next;
        slot_free_reg  <= slot_free_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_off_reg    <= res_off_next;
        res_rel_reg    <= res_rel_next;
        m_status_reg   <= m_status_next;
        m_page_reg     <= m_page_next;
        m_off_reg      <= m_off_next;
        m_rel_reg      <= m_rel_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) hdr_mem[mem_wa] <= mem_wd;
        rd_q <= hdr_mem[mem_ra];
    end

`ifndef SYNTHESIS
    a_piu_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(piu_reg) <= 32'(NUM_PAGES))
        else $error("page count past table size");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 32'd0))
        else $error("error word carries nonzero fields");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while busy");
`endif

endmodule

>>> hw/rtl/pffha_alu.sv
module pffha_alu #(
    parameter int SAT_MAX = 511
) (
    input  pffha_pkg::alu_req_t req,
    output pffha_pkg::alu_rsp_t rsp
);
    import pffha_pkg::*;

    logic [ALU_W+1:0] sum;

    // one three-input adder, one subtractor, one magnitude compare, one equality compare
    always_comb begin
        sum     = {2'b00, req.a} + {2'b00, req.b} + {2'b00, req.c};
        rsp.ge  = (req.x >= req.y);
        rsp.eq  = (req.x == req.y);
        unique case (req.op)
            ALU_ADD:     rsp.res = sum[ALU_W-1:0];
            ALU_ADD_SAT: rsp.res = (sum > (ALU_W+2)'(SAT_MAX)) ? ALU_W'(SAT_MAX)
                                                               : sum[ALU_W-1:0];
            ALU_SUB_SAT: rsp.res = (req.a > req.b) ? (req.a - req.b) : '0;
            default:     rsp.res = '0;
        endcase
    end

endmodule
